FILE: rtl/lrsc_pkg.sv
// Shared types, codes and constants of the LED ring section controller.
// Used by the interfaces, every module and the top level; depends on nothing.
`timescale 1ns / 1ps

package lrsc_pkg;

   localparam int NUM_LEDS    = 8;
   localparam int LEVEL_WIDTH = 16;

   // Item kinds.
   localparam logic REQ_PRESS = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Button codes.
   localparam logic [2:0] BTN_ENABLE   = 3'd0;
   localparam logic [2:0] BTN_BRIGHTER = 3'd1;
   localparam logic [2:0] BTN_DIMMER   = 3'd2;
   localparam logic [2:0] BTN_MODE     = 3'd3;
   localparam logic [2:0] BTN_SIZE     = 3'd4;
   localparam logic [2:0] BTN_ROTATE   = 3'd5;

   // Parameter select codes.
   localparam logic [2:0] PARAM_ENABLE   = 3'd0;
   localparam logic [2:0] PARAM_BRIGHT   = 3'd1;
   localparam logic [2:0] PARAM_COUNT    = 3'd2;
   localparam logic [2:0] PARAM_SIZE     = 3'd3;
   localparam logic [2:0] PARAM_ROTATION = 3'd4;

   localparam logic [3:0] BRIGHT_MAX     = 4'd9;
   localparam logic [3:0] SIZE_FULL      = 4'd8;
   localparam logic [3:0] SIZE_MODE_INIT = 4'd2;
   localparam logic [3:0] SIZE_ONE_WRAP  = 4'd6;
   localparam logic [3:0] SIZE_TWO_WRAP  = 4'd2;
   localparam logic [2:0] COUNT_ONE      = 3'd1;
   localparam logic [2:0] COUNT_TWO      = 3'd2;
   localparam logic [2:0] COUNT_FOUR     = 3'd4;

   typedef struct packed {
      logic       lights_on;
      logic [3:0] bright_step;
      logic [2:0] sect_count;
      logic [3:0] sect_size;
      logic [2:0] sect_rotation;
   } settings_type;

   localparam settings_type SETTINGS_RESET = '{
      lights_on:     1'b1,
      bright_step:   4'd2,
      sect_count:    3'd1,
      sect_size:     4'd8,
      sect_rotation: 3'd0
   };

   typedef logic [NUM_LEDS-1:0][LEVEL_WIDTH-1:0] level_vec_type;

   typedef struct packed {
      level_vec_type level;
      logic          param_rejected;
      logic          limit_hit;
   } result_type;

   // PWM level for each brightness step; steps past the table give 0.
   function automatic logic [LEVEL_WIDTH-1:0] level_of(input logic [3:0] step);
      logic [LEVEL_WIDTH-1:0] value;
      unique case (step)
         4'd0:    value = 16'd44;
         4'd1:    value = 16'd100;
         4'd2:    value = 16'd224;
         4'd3:    value = 16'd505;
         4'd4:    value = 16'd1136;
         4'd5:    value = 16'd2557;
         4'd6:    value = 16'd5753;
         4'd7:    value = 16'd12946;
         4'd8:    value = 16'd29127;
         4'd9:    value = 16'd65535;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

FILE: rtl/lrsc_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on lrsc_pkg for the level width.
`timescale 1ns / 1ps

interface lrsc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [2:0]  button;
   logic [2:0]  param_select;
   logic [15:0] param_value;

   modport source (output valid, req_type, button, param_select, param_value,
                   input ready);
   modport sink   (input valid, req_type, button, param_select, param_value,
                   output ready);
endinterface

interface lrsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_0;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_1;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_2;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_3;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_4;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_5;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_6;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] level_7;
   logic                             param_rejected;
   logic                             limit_hit;

   modport source (output valid, level_0, level_1, level_2, level_3, level_4,
                   level_5, level_6, level_7, param_rejected, limit_hit,
                   input ready);
   modport sink   (input valid, level_0, level_1, level_2, level_3, level_4,
                   level_5, level_6, level_7, param_rejected, limit_hit,
                   output ready);
endinterface

FILE: rtl/lrsc_ctrl.sv
// Settings registers with button and parameter-write update logic.
// Depends on lrsc_pkg.
`timescale 1ns / 1ps

module lrsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   req_type,
   input  logic [2:0]             button,
   input  logic [2:0]             param_select,
   input  logic [15:0]            param_value,
   output lrsc_pkg::settings_type next_settings,
   output logic                   param_rejected,
   output logic                   limit_hit
);

   lrsc_pkg::settings_type settings_ff;
   lrsc_pkg::settings_type settings_in;

   always_comb begin
      settings_in    = settings_ff;
      param_rejected = 1'b0;
      limit_hit      = 1'b0;
      if (req_type == lrsc_pkg::REQ_WRITE) begin
         unique case (param_select)
            lrsc_pkg::PARAM_ENABLE: begin
               settings_in.lights_on = |param_value;
            end
            lrsc_pkg::PARAM_BRIGHT: begin
               if (param_value > 16'(lrsc_pkg::BRIGHT_MAX)) begin
                  param_rejected = 1'b1;
               end else begin
                  settings_in.bright_step = param_value[3:0];
               end
            end
            lrsc_pkg::PARAM_COUNT: begin
               if (param_value == 16'(lrsc_pkg::COUNT_ONE) ||
                   param_value == 16'(lrsc_pkg::COUNT_TWO) ||
                   param_value == 16'(lrsc_pkg::COUNT_FOUR)) begin
                  settings_in.sect_count = param_value[2:0];
               end else begin
                  param_rejected = 1'b1;
               end
            end
            lrsc_pkg::PARAM_SIZE: begin
               if (param_value == 16'd0 ||
                   param_value > 16'(lrsc_pkg::SIZE_FULL)) begin
                  param_rejected = 1'b1;
               end else begin
                  settings_in.sect_size = param_value[3:0];
               end
            end
            lrsc_pkg::PARAM_ROTATION: begin
               if (param_value > 16'd7) begin
                  param_rejected = 1'b1;
               end else begin
                  settings_in.sect_rotation = param_value[2:0];
               end
            end
            default: begin
               param_rejected = 1'b1;
            end
         endcase
      end else begin
         if (button == lrsc_pkg::BTN_ENABLE) begin
            settings_in.lights_on = ~settings_ff.lights_on;
         end else if (settings_ff.lights_on) begin
            unique case (button)
               lrsc_pkg::BTN_BRIGHTER: begin
                  if (settings_ff.bright_step < lrsc_pkg::BRIGHT_MAX) begin
                     settings_in.bright_step = settings_ff.bright_step + 4'd1;
                  end else begin
                     limit_hit = 1'b1;
                  end
               end
               lrsc_pkg::BTN_DIMMER: begin
                  if (settings_ff.bright_step != 4'd0) begin
                     settings_in.bright_step = settings_ff.bright_step - 4'd1;
                  end else begin
                     limit_hit = 1'b1;
                  end
               end
               lrsc_pkg::BTN_MODE: begin
                  if (settings_ff.sect_count == lrsc_pkg::COUNT_ONE &&
                      settings_ff.sect_size == lrsc_pkg::SIZE_FULL) begin
                     settings_in.sect_size = lrsc_pkg::SIZE_MODE_INIT;
                  end else if (settings_ff.sect_count == lrsc_pkg::COUNT_ONE &&
                               settings_ff.sect_size < lrsc_pkg::SIZE_FULL) begin
                     settings_in.sect_count = lrsc_pkg::COUNT_TWO;
                     settings_in.sect_size  = lrsc_pkg::SIZE_MODE_INIT;
                  end else begin
                     settings_in.sect_count = lrsc_pkg::COUNT_ONE;
                     settings_in.sect_size  = lrsc_pkg::SIZE_FULL;
                  end
               end
               lrsc_pkg::BTN_SIZE: begin
                  // A single section cycles 1..6, a pair of sections cycles 1..2.
                  if (settings_ff.sect_count == lrsc_pkg::COUNT_ONE &&
                      settings_ff.sect_size < lrsc_pkg::SIZE_FULL) begin
                     settings_in.sect_size =
                        (settings_ff.sect_size >= lrsc_pkg::SIZE_ONE_WRAP) ?
                        4'd1 : settings_ff.sect_size + 4'd1;
                  end else if (settings_ff.sect_count == lrsc_pkg::COUNT_TWO) begin
                     settings_in.sect_size =
                        (settings_ff.sect_size >= lrsc_pkg::SIZE_TWO_WRAP) ?
                        4'd1 : settings_ff.sect_size + 4'd1;
                  end
               end
               lrsc_pkg::BTN_ROTATE: begin
                  settings_in.sect_rotation = settings_ff.sect_rotation + 3'd1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign next_settings = settings_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         settings_ff <= lrsc_pkg::SETTINGS_RESET;
      end else if (req_fire) begin
         settings_ff <= settings_in;
      end
   end

   // A refused write leaves every setting as it was.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && param_rejected |=> $stable(settings_ff))
      else $error("refused write changed the settings");

   // A press at a brightness limit leaves the step alone.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && limit_hit |=> $stable(settings_ff.bright_step))
      else $error("brightness moved past its limit");

   // Settings only move when an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(settings_ff))
      else $error("settings changed without an item");

   // The update logic keeps the section count on one of its legal values.
   assert property (@(posedge clock) disable iff (reset)
      settings_ff.sect_count == lrsc_pkg::COUNT_ONE ||
      settings_ff.sect_count == lrsc_pkg::COUNT_TWO ||
      settings_ff.sect_count == lrsc_pkg::COUNT_FOUR)
      else $error("illegal section count held");

endmodule

FILE: rtl/lrsc_level_map.sv
// Maps the settings to a lit pattern around the ring and a PWM level per LED.
// Depends on lrsc_pkg.
`timescale 1ns / 1ps

module lrsc_level_map (
   input  lrsc_pkg::settings_type  settings,
   output lrsc_pkg::level_vec_type level
);

   logic [2:0]                       eff_count;
   logic [3:0]                       eff_size;
   logic [2:0]                       half_size;
   logic [2:0]                       stride;
   logic [2:0]                       start;
   logic [2:0]                       pos_offset;
   logic [lrsc_pkg::NUM_LEDS-1:0]    lit;
   logic [lrsc_pkg::LEVEL_WIDTH-1:0] on_level;

   always_comb begin
      eff_count = (settings.sect_count == lrsc_pkg::COUNT_TWO ||
                   settings.sect_count == lrsc_pkg::COUNT_FOUR) ?
                  settings.sect_count : lrsc_pkg::COUNT_ONE;
      eff_size  = (settings.sect_size == 4'd0 ||
                   settings.sect_size > lrsc_pkg::SIZE_FULL) ?
                  lrsc_pkg::SIZE_FULL : settings.sect_size;
      half_size = eff_size[3:1];
      // Distance between section starts is the ring size over the count.
      unique case (eff_count)
         lrsc_pkg::COUNT_FOUR: stride = 3'd2;
         lrsc_pkg::COUNT_TWO:  stride = 3'd4;
         default:              stride = 3'd0;
      endcase
      start      = '0;
      pos_offset = '0;
      lit        = '0;
      for (int k = 0; k < 4; k++) begin
         start = 3'(settings.sect_rotation - half_size + 3'(3'(k) * stride));
         for (int p = 0; p < lrsc_pkg::NUM_LEDS; p++) begin
            pos_offset = 3'(3'(p) - start);
            if (3'(k) < eff_count && {1'b0, pos_offset} < eff_size) begin
               lit[p] = 1'b1;
            end
         end
      end
      on_level = settings.lights_on ? lrsc_pkg::level_of(settings.bright_step) : '0;
      for (int p = 0; p < lrsc_pkg::NUM_LEDS; p++) begin
         level[p] = lit[p] ? on_level : '0;
      end
   end

endmodule

FILE: rtl/lrsc_skid.sv
// Two-entry output buffer: a result register plus one skid register.
// Depends on lrsc_pkg for the result type.
`timescale 1ns / 1ps

module lrsc_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lrsc_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lrsc_pkg::result_type out_data
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   lrsc_pkg::result_type out_data_ff;
   lrsc_pkg::result_type skid_data_ff;
   logic                 in_fire;
   logic                 out_fire;

   assign in_ready  = ~skid_valid_ff;
   assign in_fire   = in_valid & in_ready;
   assign out_fire  = out_valid_ff & out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff || out_ready) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   // The skid register only fills behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without a result ahead of it");

   // A result that waits keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("waiting result was lost or changed");

endmodule

FILE: rtl/led_ring_section_controller_top.sv
// Top level of the LED ring section controller.
// Depends on lrsc_pkg, lrsc_if, lrsc_ctrl, lrsc_level_map and lrsc_skid.
`timescale 1ns / 1ps

// Channel   Direction  Carries
// req_chan  in         one item: press (button) or write (param_select, param_value)
// rsp_chan  out        one item per request: level_0..level_7, param_rejected, limit_hit
//
// Every request item produces exactly one response item. A request can be accepted
// in every cycle while the skid register is empty; the update of the settings and
// the ring mapping both finish in the accepting cycle, and the result is registered
// in the response register. Reset (synchronous, active high) restores enable
// on, step 2, one section of size 8, orientation 0, and empties the output.
// When the response side stalls, one more item is absorbed into a skid register
// and req_chan.ready then drops until the waiting response is taken.

module led_ring_section_controller_top (
   input logic        clock,
   input logic        reset,
   lrsc_req_if.sink   req_chan,
   lrsc_rsp_if.source rsp_chan
);

   logic                   req_fire;
   logic                   param_rejected;
   logic                   limit_hit;
   lrsc_pkg::settings_type next_settings;
   lrsc_pkg::level_vec_type level;
   lrsc_pkg::result_type   result;
   lrsc_pkg::result_type   rsp_data;

   assign req_fire = req_chan.valid & req_chan.ready;

   // The settings register updates on each accepted item; the next value is
   // what the response is computed from, so the result reflects this item.
   lrsc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_type       (req_chan.req_type),
      .button         (req_chan.button),
      .param_select   (req_chan.param_select),
      .param_value    (req_chan.param_value),
      .next_settings  (next_settings),
      .param_rejected (param_rejected),
      .limit_hit      (limit_hit)
   );

   lrsc_level_map u_level_map (
      .settings (next_settings),
      .level    (level)
   );

   assign result.level          = level;
   assign result.param_rejected = param_rejected;
   assign result.limit_hit      = limit_hit;

   // The output buffer decides when a request may be taken.
   lrsc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (result),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.level_0        = rsp_data.level[0];
   assign rsp_chan.level_1        = rsp_data.level[1];
   assign rsp_chan.level_2        = rsp_data.level[2];
   assign rsp_chan.level_3        = rsp_data.level[3];
   assign rsp_chan.level_4        = rsp_data.level[4];
   assign rsp_chan.level_5        = rsp_data.level[5];
   assign rsp_chan.level_6        = rsp_data.level[6];
   assign rsp_chan.level_7        = rsp_data.level[7];
   assign rsp_chan.param_rejected = rsp_data.param_rejected;
   assign rsp_chan.limit_hit      = rsp_data.limit_hit;

endmodule

FILE: dv/tb_led_ring_section_controller_top.sv
// Self-checking testbench for the LED ring section controller top level.
// Depends on lrsc_pkg, lrsc_if and the RTL under rtl/; a scoreboard class predicts
// every response item from its own model of the ring settings.
`timescale 1ns / 1ps

module tb_led_ring_section_controller_top;
   import lrsc_pkg::*;

   localparam int      HOLD_CYCLES   = 64;
   localparam int      HOLD_AFTER    = 500;
   localparam int      RANDOM_ITEMS  = 1325;
   localparam int      DRAIN_CYCLES  = 10;
   localparam longint  TIMEOUT_NS    = 20_000_000;

   // One request item as the sender sees it.
   typedef struct packed {
      logic        req_type;
      logic [2:0]  button;
      logic [2:0]  param_select;
      logic [15:0] param_value;
   } ring_item_type;

   // Scoreboard: keeps its own copy of the ring settings, predicts the levels
   // and flags of every accepted item, and compares each response against the
   // oldest prediction still waiting.
   class ring_level_scoreboard;
      settings_type     ring;
      result_type       pending_results[$];
      int unsigned      step_level[10] = '{44, 100, 224, 505, 1136, 2557, 5753,
                                           12946, 29127, 65535};
      int               errors;
      int               results_checked;
      int               rejected_writes;
      int               limit_hits;
      int               dark_items;

      function new();
         ring = SETTINGS_RESET;
      endfunction

      // Returns 1 when the step was already at its limit.
      function bit press_button(input logic [2:0] btn);
         bit at_limit;
         at_limit = 1'b0;
         if (btn == BTN_ENABLE) begin
            ring.lights_on = !ring.lights_on;
            return 1'b0;
         end
         // Every other button is dead while the ring is dark.
         if (!ring.lights_on) return 1'b0;
         case (btn)
            BTN_BRIGHTER: begin
               if (ring.bright_step < BRIGHT_MAX) ring.bright_step = ring.bright_step + 4'd1;
               else at_limit = 1'b1;
            end
            BTN_DIMMER: begin
               if (ring.bright_step > 0) ring.bright_step = ring.bright_step - 4'd1;
               else at_limit = 1'b1;
            end
            BTN_MODE: begin
               if (ring.sect_count == COUNT_ONE && ring.sect_size == SIZE_FULL) begin
                  ring.sect_size = SIZE_MODE_INIT;
               end else if (ring.sect_count == COUNT_ONE && ring.sect_size < SIZE_FULL) begin
                  ring.sect_count = COUNT_TWO;
                  ring.sect_size  = SIZE_MODE_INIT;
               end else begin
                  ring.sect_count = COUNT_ONE;
                  ring.sect_size  = SIZE_FULL;
               end
            end
            BTN_SIZE: begin
               if (ring.sect_count == COUNT_ONE && ring.sect_size < SIZE_FULL) begin
                  ring.sect_size = ring.sect_size + 4'd1;
                  if (ring.sect_size > SIZE_ONE_WRAP) ring.sect_size = 4'd1;
               end else if (ring.sect_count == COUNT_TWO) begin
                  ring.sect_size = ring.sect_size + 4'd1;
                  if (ring.sect_size > SIZE_TWO_WRAP) ring.sect_size = 4'd1;
               end
            end
            BTN_ROTATE: ring.sect_rotation = ring.sect_rotation + 3'd1;
            default: ;
         endcase
         return at_limit;
      endfunction

      // Returns 1 when the write is refused; a refused write leaves all settings alone.
      function bit write_setting(input logic [2:0] sel, input logic [15:0] value);
         case (sel)
            PARAM_ENABLE: begin
               ring.lights_on = (value != 0);
               return 1'b0;
            end
            PARAM_BRIGHT: begin
               if (value > BRIGHT_MAX) return 1'b1;
               ring.bright_step = value[3:0];
               return 1'b0;
            end
            PARAM_COUNT: begin
               if (value != COUNT_ONE && value != COUNT_TWO && value != COUNT_FOUR) return 1'b1;
               ring.sect_count = value[2:0];
               return 1'b0;
            end
            PARAM_SIZE: begin
               if (value < 1 || value > SIZE_FULL) return 1'b1;
               ring.sect_size = value[3:0];
               return 1'b0;
            end
            PARAM_ROTATION: begin
               if (value > 7) return 1'b1;
               ring.sect_rotation = value[2:0];
               return 1'b0;
            end
            default: return 1'b1;
         endcase
      endfunction

      // Applies one accepted item to the settings and predicts its response.
      function void apply_item(input ring_item_type item);
         result_type  want;
         bit          lit[NUM_LEDS];
         int unsigned level;
         int          span;
         int          first;
         want = '0;
         foreach (lit[p]) lit[p] = 1'b0;
         if (item.req_type == REQ_WRITE)
            want.param_rejected = write_setting(item.param_select, item.param_value);
         else
            want.limit_hit = press_button(item.button);
         rejected_writes += want.param_rejected;
         limit_hits      += want.limit_hit;
         if (!ring.lights_on) dark_items++;

         level = (ring.lights_on && ring.bright_step < 10) ? step_level[ring.bright_step] : 0;
         span  = NUM_LEDS / ring.sect_count;
         // Each section is centered on the orientation and spaced evenly round the ring.
         for (int k = 0; k < ring.sect_count; k++) begin
            first = NUM_LEDS + ring.sect_rotation - ring.sect_size / 2 + k * span;
            for (int j = 0; j < ring.sect_size; j++) lit[(first + j) % NUM_LEDS] = 1'b1;
         end
         foreach (lit[p]) want.level[p] = lit[p] ? level[LEVEL_WIDTH-1:0] : '0;
         pending_results.push_back(want);
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] MISMATCH on result %0d: %s", $realtime, results_checked, what);
         errors++;
      endtask

      task check_result(input result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no item pending");
            return;
         end
         want = pending_results.pop_front();
         for (int p = 0; p < NUM_LEDS; p++) begin
            if (got.level[p] !== want.level[p])
               report_mismatch($sformatf("level_%0d got %0d, predicted %0d",
                                         p, got.level[p], want.level[p]));
         end
         if (got.param_rejected !== want.param_rejected)
            report_mismatch($sformatf("param_rejected got %b, predicted %b",
                                      got.param_rejected, want.param_rejected));
         if (got.limit_hit !== want.limit_hit)
            report_mismatch($sformatf("limit_hit got %b, predicted %b",
                                      got.limit_hit, want.limit_hit));
         results_checked++;
      endtask

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   lrsc_req_if req_chan ();
   lrsc_rsp_if rsp_chan ();

   led_ring_section_controller_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ring_level_scoreboard ring_sb = new();
   int  items_accepted = 0;
   bit  hold_done = 1'b0;

   // 20 ns clock period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Gap lengths shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // A press item; the write fields are don't-care and are filled at random
   // so that their bits also toggle.
   function automatic ring_item_type make_press(input logic [2:0] btn);
      ring_item_type item;
      item.req_type     = REQ_PRESS;
      item.button       = btn;
      item.param_select = 3'($urandom_range(0, 7));
      item.param_value  = 16'($urandom);
      return item;
   endfunction

   function automatic ring_item_type make_write(input logic [2:0] sel, input logic [15:0] value);
      ring_item_type item;
      item.req_type     = REQ_WRITE;
      item.button       = 3'($urandom_range(0, 7));
      item.param_select = sel;
      item.param_value  = value;
      return item;
   endfunction

   // Random traffic is mostly legal presses and writes with values near the
   // legal ranges, so that the section modes and brightness walk through all of
   // their states; the rest is full-range values and unknown codes.
   function automatic ring_item_type make_random_item();
      int          roll;
      logic [2:0]  btn;
      logic [2:0]  sel;
      logic [15:0] value;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         // Enable toggles are kept rare so that most presses see a lit ring.
         btn = ($urandom_range(0, 99) < 8) ? BTN_ENABLE : 3'($urandom_range(1, 5));
         return make_press(btn);
      end else if (roll < 92) begin
         sel   = 3'($urandom_range(0, 4));
         value = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 9)) : 16'($urandom);
         return make_write(sel, value);
      end else if (roll < 96) begin
         return make_write(3'($urandom_range(5, 7)), 16'($urandom));
      end
      return make_press(3'($urandom_range(6, 7)));
   endfunction

   // Offers one item after an optional idle gap and returns at the edge where it
   // is taken. Valid is left high, so a back-to-back item needs no extra edge.
   task automatic offer_item(input ring_item_type item, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= item.req_type;
      req_chan.button       <= item.button;
      req_chan.param_select <= item.param_select;
      req_chan.param_value  <= item.param_value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   task automatic offer_press(input logic [2:0] btn);
      offer_item(make_press(btn), pick_gap());
   endtask

   task automatic offer_write(input logic [2:0] sel, input logic [15:0] value);
      offer_item(make_write(sel, value), pick_gap());
   endtask

   // Both channels are sampled at the rising edge, before any of this edge's
   // nonblocking updates land, so the values seen are the ones the block saw.
   // A response is checked before the item accepted at the same edge is noted;
   // the response is registered, so it always comes at a later edge and order is preserved.
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.level[0]       = rsp_chan.level_0;
            got.level[1]       = rsp_chan.level_1;
            got.level[2]       = rsp_chan.level_2;
            got.level[3]       = rsp_chan.level_3;
            got.level[4]       = rsp_chan.level_4;
            got.level[5]       = rsp_chan.level_5;
            got.level[6]       = rsp_chan.level_6;
            got.level[7]       = rsp_chan.level_7;
            got.param_rejected = rsp_chan.param_rejected;
            got.limit_hit      = rsp_chan.limit_hit;
            ring_sb.check_result(got);
         end
         if (req_chan.valid && req_chan.ready) begin
            ring_sb.apply_item({req_chan.req_type, req_chan.button,
                                req_chan.param_select, req_chan.param_value});
            items_accepted++;
         end
      end
   end

   // Response side. It stalls at random, has calm stretches with ready held
   // high, and once holds off for a long stretch while the sender keeps
   // offering, so that the skid register fills and the input stalls.
   initial begin
      int hold_left;
      int stall_left;
      int calm_left;
      rsp_chan.ready = 1'b0;
      hold_left  = 0;
      stall_left = 0;
      calm_left  = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
            else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 150);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      ring_item_type item;
      int            gap;
      req_chan.valid        = 1'b0;
      req_chan.req_type     = REQ_PRESS;
      req_chan.button       = BTN_ENABLE;
      req_chan.param_select = PARAM_ENABLE;
      req_chan.param_value  = '0;
      reset                 = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Start from the reset settings, then hit both brightness
      // limits, walk the section modes and sizes, and try every parameter write
      // with a legal value and each range-checked one with an illegal value too.
      offer_press(BTN_ROTATE);
      offer_write(PARAM_BRIGHT, 16'd9);
      offer_press(BTN_BRIGHTER);                  // already at the top step
      offer_write(PARAM_BRIGHT, 16'd0);
      offer_press(BTN_DIMMER);                    // already at the bottom step
      offer_press(BTN_BRIGHTER);
      offer_write(PARAM_BRIGHT, 16'd10);          // just past the legal range
      offer_write(PARAM_BRIGHT, 16'hFFFF);
      offer_press(BTN_MODE);                      // full ring to one small section
      offer_press(BTN_SIZE);
      offer_press(BTN_MODE);                      // one section to two sections
      offer_press(BTN_SIZE);
      offer_press(BTN_SIZE);
      offer_press(BTN_MODE);                      // back to the full ring
      offer_write(PARAM_COUNT, 16'd4);
      offer_write(PARAM_COUNT, 16'd3);
      offer_write(PARAM_SIZE, 16'd0);
      offer_write(PARAM_SIZE, 16'd1);
      offer_write(PARAM_SIZE, 16'd9);
      offer_write(PARAM_ROTATION, 16'd7);
      offer_write(PARAM_ROTATION, 16'd8);
      offer_write(3'd5, 16'd1);                   // unknown parameters
      offer_write(3'd7, 16'h7FFF);
      offer_press(3'd6);                          // unknown buttons
      offer_press(3'd7);
      offer_write(PARAM_ENABLE, 16'd0);
      offer_press(BTN_BRIGHTER);                  // ignored while dark, no limit flag
      offer_press(BTN_ENABLE);
      offer_press(BTN_ENABLE);
      offer_write(PARAM_ENABLE, 16'h8000);        // any nonzero value enables

      // Random part. Every fourth window of 100 items is sent back to back.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         item = make_random_item();
         gap  = ((n / 100) % 4 == 3) ? 0 : pick_gap();
         offer_item(item, gap);
      end
      req_chan.valid <= 1'b0;

      while (ring_sb.pending() != 0) @(posedge clock);
      // Let a stray extra response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d refused writes, %0d brightness limit hits,",
               items_accepted, ring_sb.rejected_writes, ring_sb.limit_hits);
      $display("%0d items while dark; checked %0d responses, with a %0d-cycle hold-off.",
               ring_sb.dark_items, ring_sb.results_checked, HOLD_CYCLES);
      if (ring_sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d responses still pending", ring_sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
